@@ rtl/core/trd_pkg.sv @@
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the TGA pixel decoder
// Register indexes, pixel format codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 27;
  localparam int unsigned TotalW    = 27;
  localparam int unsigned IndexW    = 26;
  localparam int unsigned PixelW    = 32;
  localparam int unsigned RunW      = 8;

  // Hard ceiling on the pixel total (2^26)
  localparam longint unsigned PixelLimit = 64'd67108864;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COMPRESSED   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_TOTAL  = 2'd2;

  // Pixel format codes; any other code decodes as BGRA
  localparam logic [1:0] FMT_GREY = 2'd0;
  localparam logic [1:0] FMT_BGR  = 2'd1;
  localparam logic [1:0] FMT_BGRA = 2'd2;

  // Result pixel counts
  localparam logic [1:0] COUNT_ONE = 2'd1;
  localparam logic [1:0] COUNT_TWO = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic emit;     // load the next result into the output register
  } trd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pixel_done;   // the presented byte completes a pixel
    logic last_emit;    // the pending result is the final one of this byte
  } trd_status_t;

endpackage

@@ rtl/core/trd_ctrl.sv @@
// ----------------------------------------------------------------------------
// trd_ctrl: decoder sequencer
// Two-state machine: take bytes, or emit the pixel pairs of one byte.
// Owns the output valid flag and both stall/valid handshakes.
// ----------------------------------------------------------------------------
module trd_ctrl
  import trd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  trd_status_t status_i,
  output trd_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'b01,
    ST_EMIT   = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_ACCEPT);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.accept = 1'b0;
    cmd_o.emit   = 1'b0;
    state_d      = state_q;
    case (state_q)
      ST_ACCEPT: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.pixel_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = slot_free;
        if (slot_free && status_i.last_emit) begin
          state_d = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase
  end

  // Hold the result until the transfer, reload when a new one is emitted
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCEPT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_enter_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.pixel_done) |=> (state_q == ST_EMIT))
    else $error("pixel-completing byte did not start emission");

  a_leave_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && status_i.last_emit) |=> (state_q == ST_ACCEPT && out_valid_q))
    else $error("final result did not return to accept with output loaded");

  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCEPT) |-> !cmd_o.emit)
    else $error("emit issued while taking bytes");

endmodule

@@ rtl/core/trd_datapath.sv @@
// ----------------------------------------------------------------------------
// trd_datapath: decode state, pixel assembly and result register
// Packet header parsing, byte gathering, BGR(A) swap, run expansion in pairs.
// ----------------------------------------------------------------------------
module trd_datapath
  import trd_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 8192
)(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trd_cmd_t            cmd_i,
  output trd_status_t         status_o,
  input  logic                action_i,
  input  logic [7:0]          data_byte_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [PixelW-1:0]   first_pixel_o,
  output logic [PixelW-1:0]   second_pixel_o,
  output logic [1:0]          pixel_count_o,
  output logic [IndexW-1:0]   first_index_o,
  output logic                last_o,
  output logic                frame_done_o
);

  localparam longint unsigned SideSq   = longint'(MAX_SIDE) * longint'(MAX_SIDE);
  localparam longint unsigned CapL     = (SideSq > PixelLimit) ? PixelLimit : SideSq;
  localparam logic [TotalW-1:0] TotalCap = CapL[TotalW-1:0];

  // Configuration
  logic [1:0]        fmt_q;
  logic              comp_q;
  logic [TotalW-1:0] total_q;

  // Decode state
  logic              expect_hdr_q, expect_hdr_d;
  logic              run_mode_q, run_mode_d;
  logic [RunW-1:0]   pkt_left_q, pkt_left_d;
  logic [23:0]       gather_q, gather_d;
  logic [1:0]        slot_q, slot_d;
  logic [TotalW-1:0] written_q, written_d;
  logic              finished_q, finished_d;

  // Pending emission
  logic [PixelW-1:0] px_q, px_d;
  logic [RunW-1:0]   n_q, n_d;

  // Result register
  logic [PixelW-1:0] first_q, second_q;
  logic [1:0]        count_q;
  logic [IndexW-1:0] index_q;
  logic              last_q, done_q;

  logic [2:0]        bpp;
  logic [2:0]        slot_next;
  logic              stopped;
  logic              is_header;
  logic [PixelW-1:0] px_asm;
  logic [TotalW-1:0] left;
  logic [RunW-1:0]   run_len;
  logic [RunW-1:0]   pkt_dec;
  logic [1:0]        emit_cnt;
  logic [TotalW-1:0] written_add;

  always_comb begin
    case (fmt_q)
      FMT_GREY: bpp = 3'd1;
      FMT_BGR:  bpp = 3'd3;
      default:  bpp = 3'd4;
    endcase
  end

  assign slot_next = {1'b0, slot_q} + 3'd1;
  assign stopped   = finished_q || (written_q >= total_q);
  assign is_header = comp_q && expect_hdr_q;

  assign status_o.pixel_done = !action_i && !stopped && !is_header && (slot_next >= bpp);
  assign status_o.last_emit  = (n_q <= RunW'(2));

  // Swap B,G,R(,A) into R,G,B(,A)
  always_comb begin
    case (bpp)
      3'd1:    px_asm = {24'd0, data_byte_i};
      3'd3:    px_asm = {8'd0, gather_q[7:0], gather_q[15:8], data_byte_i};
      default: px_asm = {data_byte_i, gather_q[7:0], gather_q[15:8], gather_q[23:16]};
    endcase
  end

  assign left    = total_q - written_q;
  assign pkt_dec = (pkt_left_q != '0) ? pkt_left_q - RunW'(1) : '0;

  always_comb begin
    run_len = (pkt_left_q == '0) ? RunW'(1) : pkt_left_q;
    if (TotalW'(run_len) > left) begin
      run_len = left[RunW-1:0];
    end
  end

  assign emit_cnt    = (n_q >= RunW'(2)) ? COUNT_TWO : COUNT_ONE;
  assign written_add = written_q + TotalW'(emit_cnt);

  always_comb begin
    expect_hdr_d = expect_hdr_q;
    run_mode_d   = run_mode_q;
    pkt_left_d   = pkt_left_q;
    gather_d     = gather_q;
    slot_d       = slot_q;
    written_d    = written_q;
    finished_d   = finished_q;
    px_d         = px_q;
    n_d          = n_q;
    if (cmd_i.accept) begin
      if (action_i) begin
        expect_hdr_d = 1'b1;
        run_mode_d   = 1'b0;
        pkt_left_d   = '0;
        gather_d     = '0;
        slot_d       = '0;
        written_d    = '0;
        finished_d   = 1'b0;
      end else if (stopped) begin
        finished_d = 1'b1;
      end else if (is_header) begin
        pkt_left_d   = {1'b0, data_byte_i[6:0]} + RunW'(1);
        run_mode_d   = data_byte_i[7];
        expect_hdr_d = 1'b0;
        gather_d     = '0;
        slot_d       = '0;
      end else if (slot_next < bpp) begin
        case (slot_q)
          2'd0:    gather_d[7:0]   = gather_q[7:0]   | data_byte_i;
          2'd1:    gather_d[15:8]  = gather_q[15:8]  | data_byte_i;
          2'd2:    gather_d[23:16] = gather_q[23:16] | data_byte_i;
          default: gather_d        = gather_q;
        endcase
        slot_d = slot_next[1:0];
      end else begin
        px_d     = px_asm;
        gather_d = '0;
        slot_d   = '0;
        if (comp_q && run_mode_q) begin
          n_d          = run_len;
          pkt_left_d   = '0;
          expect_hdr_d = 1'b1;
        end else begin
          n_d = RunW'(1);
          if (comp_q) begin
            pkt_left_d   = pkt_dec;
            expect_hdr_d = (pkt_dec == '0);
          end
        end
      end
    end else if (cmd_i.emit) begin
      // advance the run by one result
      written_d = written_add;
      n_d       = n_q - RunW'(emit_cnt);
      if (written_add >= total_q) begin
        finished_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_BGRA;
      comp_q  <= 1'b1;
      total_q <= TotalW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PIXEL_FORMAT: fmt_q  <= cfg_data_i[1:0];
        CFG_COMPRESSED:   comp_q <= cfg_data_i[0];
        CFG_PIXEL_TOTAL:  total_q <= (cfg_data_i[TotalW-1:0] > TotalCap) ?
                                     TotalCap : cfg_data_i[TotalW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
      run_mode_q   <= 1'b0;
      pkt_left_q   <= '0;
      gather_q     <= '0;
      slot_q       <= '0;
      written_q    <= '0;
      finished_q   <= 1'b0;
      n_q          <= '0;
    end else begin
      expect_hdr_q <= expect_hdr_d;
      run_mode_q   <= run_mode_d;
      pkt_left_q   <= pkt_left_d;
      gather_q     <= gather_d;
      slot_q       <= slot_d;
      written_q    <= written_d;
      finished_q   <= finished_d;
      n_q          <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    if (cmd_i.emit) begin
      first_q  <= px_q;
      second_q <= (emit_cnt == COUNT_TWO) ? px_q : '0;
      count_q  <= emit_cnt;
      index_q  <= written_q[IndexW-1:0];
      last_q   <= status_o.last_emit;
      done_q   <= (written_add >= total_q);
    end
  end

  assign first_pixel_o  = first_q;
  assign second_pixel_o = second_q;
  assign pixel_count_o  = count_q;
  assign first_index_o  = index_q;
  assign last_o         = last_q;
  assign frame_done_o   = done_q;

endmodule

@@ rtl/core/tga_rle_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: TGA pixel-data byte stream to RGB(A) pixels
// Run-length or plain decode, BGR(A) swap, up to two pixels per result.
//
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i/in_stall_o   action_i, data_byte_i
//   output   out        out_valid_o/out_stall_i pixels, count, index, flags
//   config   in         cfg_we_i                cfg_index_i, cfg_data_i
//
// A byte that completes a pixel yields n pixels (up to 128 for a run
// packet); the result emitter loads them into the output register in
// results of up to two pixels, one result per cycle while the output
// does not stall.
// in_stall_o is high while a byte's results are emitted.
// rst_ni clears the decode state and loads the register reset values.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
  import trd_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 8192
)(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixelW-1:0]   first_pixel_o,
  output logic [PixelW-1:0]   second_pixel_o,
  output logic [1:0]          pixel_count_o,
  output logic [IndexW-1:0]   first_index_o,
  output logic                last_o,
  output logic                frame_done_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  trd_cmd_t    cmd;
  trd_status_t status;

  trd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  trd_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .data_byte_i    (data_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .first_pixel_o  (first_pixel_o),
    .second_pixel_o (second_pixel_o),
    .pixel_count_o  (pixel_count_o),
    .first_index_o  (first_index_o),
    .last_o         (last_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

@@ tb/sv/tga_rle_pixel_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_tb: self-checking bench for the TGA pixel decoder
// Drives byte streams (run-length packets, plain pixels, restarts, noise)
// under random idling and one long output hold-off. A scoreboard decodes
// every accepted byte on its own and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_tb;
  import trd_pkg::*;

  localparam int unsigned MAX_SIDE     = 8192;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam logic        ACT_DATA     = 1'b0;
  localparam logic        ACT_RESTART  = 1'b1;
  // Unnamed format code, decoded as BGRA
  localparam logic [1:0]  FMT_SPARE    = 2'd3;

  typedef struct {
    logic [PixelW-1:0] first_pixel;
    logic [PixelW-1:0] second_pixel;
    logic [1:0]        count;
    logic [IndexW-1:0] index;
    logic              last;
    logic              done;
  } pixel_result_t;

  class rle_pixel_scoreboard;
    pixel_result_t   expected_pixels[$];
    int unsigned     mismatches;
    longint unsigned total_cap;
    logic [1:0]      fmt;
    bit              rle;
    int unsigned     total_reg;
    bit              want_header;
    bit              run;
    int unsigned     pkt_left;
    logic [23:0]     gather;
    int unsigned     slot;
    int unsigned     written;
    bit              frame_over;

    function new(longint unsigned side);
      total_cap = side * side;
      if (total_cap > PixelLimit) total_cap = PixelLimit;
      fmt = FMT_BGRA;
      rle = 1'b1;
      total_reg = 1;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      want_header = 1'b1;
      run = 1'b0;
      pkt_left = 0;
      gather = '0;
      slot = 0;
      written = 0;
      frame_over = 1'b0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_PIXEL_FORMAT: fmt = val[1:0];
        CFG_COMPRESSED:   rle = val[0];
        CFG_PIXEL_TOTAL:  total_reg = 32'(val);
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    // Decode one accepted byte; returns 1 when the byte was not ignored
    function bit take_byte(logic act, logic [7:0] d);
      int unsigned   limit;
      int unsigned   bpp;
      int unsigned   n;
      logic [31:0]   px;
      pixel_result_t r;
      limit = (longint'(total_reg) > total_cap) ? int'(total_cap) : total_reg;
      if (act == ACT_RESTART) begin
        clear_frame();
        return 1'b0;
      end
      if (frame_over || written >= limit) begin
        frame_over = 1'b1;
        return 1'b0;
      end
      if (rle && want_header) begin
        pkt_left = d[6:0] + 1;
        run = d[7];
        want_header = 1'b0;
        gather = '0;
        slot = 0;
        return 1'b1;
      end
      case (fmt)
        FMT_GREY: bpp = 1;
        FMT_BGR:  bpp = 3;
        default:  bpp = 4;
      endcase
      if (slot + 1 < bpp) begin
        gather = gather | (24'(d) << (8 * slot));
        slot = slot + 1;
        return 1'b1;
      end
      // Swap BGR(A) to RGB(A)
      case (bpp)
        1:       px = {24'h0, d};
        3:       px = {8'h0, gather[7:0], gather[15:8], d};
        default: px = {d, gather[7:0], gather[15:8], gather[23:16]};
      endcase
      gather = '0;
      slot = 0;
      if (rle && run) begin
        n = (pkt_left == 0) ? 1 : pkt_left;
        if (n > limit - written) n = limit - written;
        pkt_left = 0;
        want_header = 1'b1;
      end else begin
        n = 1;
        if (rle) begin
          if (pkt_left > 0) pkt_left = pkt_left - 1;
          if (pkt_left == 0) want_header = 1'b1;
        end
      end
      while (n > 0) begin
        r.count = (n >= 2) ? COUNT_TWO : COUNT_ONE;
        r.first_pixel = px;
        r.second_pixel = (n >= 2) ? px : '0;
        r.index = written[IndexW-1:0];
        written = written + r.count;
        n = n - r.count;
        r.done = (written >= limit);
        if (r.done) frame_over = 1'b1;
        r.last = (n == 0);
        expected_pixels.push_back(r);
      end
      return 1'b1;
    endfunction

    function void check_pixels(pixel_result_t got);
      pixel_result_t e;
      if (expected_pixels.size() == 0) begin
        $error("result transfer with no pixel pending: index %0d", got.index);
        mismatches++;
        return;
      end
      e = expected_pixels.pop_front();
      if (got.first_pixel !== e.first_pixel) begin
        $error("first_pixel: expected %h, got %h", e.first_pixel, got.first_pixel);
        mismatches++;
      end
      if (got.second_pixel !== e.second_pixel) begin
        $error("second_pixel: expected %h, got %h", e.second_pixel, got.second_pixel);
        mismatches++;
      end
      if (got.count !== e.count) begin
        $error("pixel_count: expected %0d, got %0d", e.count, got.count);
        mismatches++;
      end
      if (got.index !== e.index) begin
        $error("first_index: expected %0d, got %0d", e.index, got.index);
        mismatches++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %b, got %b", e.last, got.last);
        mismatches++;
      end
      if (got.done !== e.done) begin
        $error("frame_done: expected %b, got %b", e.done, got.done);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                action;
  logic [7:0]          data_byte;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PixelW-1:0]   first_pixel;
  logic [PixelW-1:0]   second_pixel;
  logic [1:0]          pixel_count;
  logic [IndexW-1:0]   first_index;
  logic                last;
  logic                frame_done;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  rle_pixel_scoreboard sb;
  int unsigned         useful_items = 0;
  int unsigned         results_seen = 0;
  int unsigned         cycles = 0;
  int unsigned         hold_left = 0;
  bit                  pressure_done = 1'b0;
  bit                  offering = 1'b0;

  tga_rle_pixel_decoder #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .first_pixel_o (first_pixel),
    .second_pixel_o(second_pixel),
    .pixel_count_o (pixel_count),
    .first_index_o (first_index),
    .last_o        (last),
    .frame_done_o  (frame_done),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tga_rle_pixel_decoder: mismatch");
      $finish;
    end
  end

  // Sample both channels mid-cycle; a transfer completes at the next rising edge
  always @(negedge clk) begin
    pixel_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        void'(sb.take_byte(action, data_byte));
        useful_items++;
      end
      if (out_valid && !out_stall) begin
        got.first_pixel = first_pixel;
        got.second_pixel = second_pixel;
        got.count = pixel_count;
        got.index = first_index;
        got.last = last;
        got.done = frame_done;
        sb.check_pixels(got);
        results_seen++;
      end
      offering = in_valid;
    end
  end

  // Output side: random stalls, one long hold-off, and a stall-free stretch
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && results_seen >= 80 && offering) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      pressure_done <= 1'b1;
    end else if (results_seen >= 100 && results_seen < 180) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 34);
    end
  end

  task automatic send_byte(input logic act, input logic [7:0] d);
    bit taken;
    while (!(useful_items >= 120 && useful_items < 200) && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    data_byte <= d;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  // Drop valid, drain all pending pixels, then give the block time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase();
    logic [1:0]          fmt;
    bit                  rle;
    logic [CfgDataW-1:0] total;
    int unsigned         bpp;
    int unsigned         cnt;
    int unsigned         nbytes;
    int unsigned         len;
    int unsigned         sent;
    bit                  run;
    settle();
    fmt = 2'($urandom_range(3));
    rle = ($urandom_range(3) != 0);
    case ($urandom_range(15))
      0:       total = '0;
      1:       total = '1;
      2:       total = CfgDataW'(PixelLimit);
      3:       total = CfgDataW'($urandom());
      4:       total = 1;
      5:       total = 2;
      default: total = CfgDataW'($urandom_range(400, 16));
    endcase
    write_reg(CFG_PIXEL_FORMAT, CfgDataW'(fmt));
    write_reg(CFG_COMPRESSED, CfgDataW'(rle));
    write_reg(CFG_PIXEL_TOTAL, total);
    cfg_we <= 1'b0;
    case (fmt)
      FMT_GREY: bpp = 1;
      FMT_BGR:  bpp = 3;
      default:  bpp = 4;
    endcase
    if ($urandom_range(9) != 0) send_byte(ACT_RESTART, 8'($urandom_range(255)));
    len = $urandom_range(50, 20);
    sent = 0;
    while (sent < len) begin
      if ($urandom_range(19) == 0) begin
        // noise: a stray byte or a restart
        send_byte($urandom_range(3) == 0 ? ACT_RESTART : ACT_DATA,
                  8'($urandom_range(255)));
        sent++;
      end else if (rle) begin
        run = 1'($urandom_range(1));
        case ($urandom_range(9))
          0:       cnt = 127;
          1:       cnt = $urandom_range(127);
          default: cnt = $urandom_range(7);
        endcase
        if (!run) cnt = cnt % 16;
        send_byte(ACT_DATA, {run, cnt[6:0]});
        sent++;
        nbytes = run ? bpp : (cnt + 1) * bpp;
        for (int unsigned i = 0; i < nbytes; i++) begin
          // cut a packet short now and then
          if ($urandom_range(39) == 0) break;
          send_byte(ACT_DATA, 8'($urandom_range(255)));
          sent++;
        end
      end else begin
        for (int unsigned i = 0; i < bpp; i++) begin
          send_byte(ACT_DATA, 8'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb = new(MAX_SIDE);
    rst_n = 1'b0;
    in_valid = 1'b0;
    action = ACT_DATA;
    data_byte = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PIXEL_FORMAT;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one-pixel BGRA run, then a byte past the final pixel
    send_byte(ACT_DATA, 8'h80);
    send_byte(ACT_DATA, 8'h00);
    send_byte(ACT_DATA, 8'hFF);
    send_byte(ACT_DATA, 8'h5A);
    send_byte(ACT_DATA, 8'hA5);
    send_byte(ACT_DATA, 8'h3C);
    send_byte(ACT_RESTART, 8'hFF);

    // Grey, full 128-pixel run cut to five pixels
    settle();
    write_reg(CFG_PIXEL_FORMAT, CfgDataW'(FMT_GREY));
    write_reg(CFG_PIXEL_TOTAL, 5);
    cfg_we <= 1'b0;
    send_byte(ACT_DATA, 8'hFF);
    send_byte(ACT_DATA, 8'h81);
    send_byte(ACT_DATA, 8'h00);
    send_byte(ACT_RESTART, 8'h00);

    // Spare format code, total beyond the ceiling, one raw pixel
    settle();
    write_reg(CFG_PIXEL_FORMAT, CfgDataW'(FMT_SPARE));
    write_reg(CFG_PIXEL_TOTAL, '1);
    cfg_we <= 1'b0;
    send_byte(ACT_DATA, 8'h00);
    send_byte(ACT_DATA, 8'h11);
    send_byte(ACT_DATA, 8'h22);
    send_byte(ACT_DATA, 8'h33);
    send_byte(ACT_DATA, 8'h44);

    // Plain BGR with a zero total: every byte is dropped
    settle();
    write_reg(CFG_COMPRESSED, '0);
    write_reg(CFG_PIXEL_FORMAT, CfgDataW'(FMT_BGR));
    write_reg(CFG_PIXEL_TOTAL, 0);
    cfg_we <= 1'b0;
    send_byte(ACT_RESTART, 8'h7F);
    send_byte(ACT_DATA, 8'hC3);
    send_byte(ACT_DATA, 8'h3C);

    // Switch to grey while a BGR pixel is half gathered
    settle();
    write_reg(CFG_PIXEL_TOTAL, 3);
    cfg_we <= 1'b0;
    send_byte(ACT_RESTART, 8'h00);
    send_byte(ACT_DATA, 8'h69);
    send_byte(ACT_DATA, 8'hF0);
    settle();
    write_reg(CFG_PIXEL_FORMAT, CfgDataW'(FMT_GREY));
    cfg_we <= 1'b0;
    send_byte(ACT_DATA, 8'h96);

    settle();
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) random_phase();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tga_rle_pixel_decoder: match");
    end else begin
      $display("tga_rle_pixel_decoder: mismatch");
    end
    $finish;
  end

endmodule
